### hw/rtl/magic_length_frame_deframer_defines.svh
// Assertion macros shared by the deframer checker.
// No dependencies; included by the checker file only.
`ifndef MAGIC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH
`define MAGIC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH

// Concurrent assertion on the rising edge of clk_i, masked while in reset
`define MLFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define MLFD_ASSERT_NEVER(lbl, cond, msg) \
  `MLFD_ASSERT(lbl, !(cond), msg)

`endif

### hw/rtl/mlfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the magic/length frame deframer.
// No dependencies; imported by the parser, the output register and the top level.
package mlfd_pkg;

  // Frame format
  localparam logic [7:0]  MagicByte0     = 8'h44;  // 'D'
  localparam logic [7:0]  MagicByte1     = 8'h45;  // 'E'
  localparam logic [7:0]  MagicByte2     = 8'h56;  // 'V'
  localparam int unsigned TrailerBytes   = 1;      // checksum bytes after payload, 1..4
  localparam logic [15:0] MaxLenReset    = 16'd255;

  // Body byte index: covers a full 16-bit length plus the trailer
  localparam int unsigned IdxWidth = 17;

  // Magic match progress
  localparam logic [1:0] HuntNone = 2'd0;
  localparam logic [1:0] HuntGotD = 2'd1;
  localparam logic [1:0] HuntGotE = 2'd2;

  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhAddr = 2'd1,
    PhLen  = 2'd2,
    PhBody = 2'd3
  } phase_e;

  // One outgoing transaction
  typedef struct packed {
    logic        last;
    logic        is_trailer;
    logic [7:0]  data_byte;
    logic [15:0] payload_length;
    logic [15:0] source_address;
  } result_t;

endpackage

### hw/rtl/mlfd_parser.sv
`timescale 1ns / 1ps
// Byte-level frame parser: magic hunt, header capture, body indexing.
// Depends on mlfd_pkg.
module mlfd_parser
  import mlfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        byte_take_i,
  input  logic [7:0]  byte_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  localparam logic [IdxWidth:0] TrailerExt = (IdxWidth + 1)'(TrailerBytes);

  phase_e              phase_q, phase_d;
  logic [1:0]          hunt_q, hunt_d;
  logic                hdr_hi_q, hdr_hi_d;
  logic [15:0]         addr_q, addr_d;
  logic [15:0]         len_q, len_d;
  logic [IdxWidth-1:0] idx_q, idx_d;
  logic [15:0]         max_len_q;

  logic [15:0] full_len;
  logic        is_trailer;
  logic        is_last;

  // Position of the current body byte relative to payload and trailer
  assign full_len   = {byte_i, len_q[7:0]};
  assign is_trailer = idx_q >= {1'b0, len_q};
  assign is_last    = ({1'b0, idx_q} + 1'b1) >= ({2'b00, len_q} + TrailerExt);

  // Next state
  always_comb begin
    phase_d  = phase_q;
    hunt_d   = hunt_q;
    hdr_hi_d = hdr_hi_q;
    addr_d   = addr_q;
    len_d    = len_q;
    idx_d    = idx_q;
    if (byte_take_i) begin
      unique case (phase_q)
        PhHunt: begin
          // a mismatch drops the partial match without rechecking the byte
          priority if (byte_i == MagicByte0 && hunt_q == HuntNone) begin
            hunt_d = HuntGotD;
          end else if (byte_i == MagicByte1 && hunt_q == HuntGotD) begin
            hunt_d = HuntGotE;
          end else if (byte_i == MagicByte2 && hunt_q == HuntGotE) begin
            hunt_d   = HuntNone;
            hdr_hi_d = 1'b0;
            phase_d  = PhAddr;
          end else begin
            hunt_d = HuntNone;
          end
        end
        PhAddr: begin
          if (!hdr_hi_q) begin
            addr_d[7:0] = byte_i;
            hdr_hi_d    = 1'b1;
          end else begin
            addr_d[15:8] = byte_i;
            hdr_hi_d     = 1'b0;
            phase_d      = PhLen;
          end
        end
        PhLen: begin
          if (!hdr_hi_q) begin
            len_d[7:0] = byte_i;
            hdr_hi_d   = 1'b1;
          end else begin
            len_d[15:8] = byte_i;
            hdr_hi_d    = 1'b0;
            idx_d       = '0;
            // oversized frames are dropped here
            phase_d     = (full_len > max_len_q) ? PhHunt : PhBody;
          end
        end
        PhBody: begin
          if (is_last) begin
            phase_d = PhHunt;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        default: phase_d = PhHunt;
      endcase
    end
  end

  // Result for the byte being taken
  assign res_valid_o          = byte_take_i && (phase_q == PhBody);
  assign res_o.source_address = addr_q;
  assign res_o.payload_length = len_q;
  assign res_o.data_byte      = byte_i;
  assign res_o.is_trailer     = is_trailer;
  assign res_o.last           = is_last;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      hunt_q    <= HuntNone;
      hdr_hi_q  <= 1'b0;
      addr_q    <= '0;
      len_q     <= '0;
      idx_q     <= '0;
      max_len_q <= MaxLenReset;
    end else begin
      phase_q  <= phase_d;
      hunt_q   <= hunt_d;
      hdr_hi_q <= hdr_hi_d;
      addr_q   <= addr_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

endmodule

### hw/rtl/mlfd_out_reg.sv
`timescale 1ns / 1ps
// Output register stage driving the master stream.
// Depends on mlfd_pkg.
module mlfd_out_reg
  import mlfd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  // Free now, or emptied by the transaction at this edge
  assign room_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (room_o) begin
      valid_q <= res_valid_i;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (room_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

### hw/rtl/magic_length_frame_deframer.sv
`timescale 1ns / 1ps
// Top level of the magic/length frame deframer.
// Depends on mlfd_pkg, mlfd_parser and mlfd_out_reg.

// Takes one byte per cycle on the slave stream while the output register has
// room, hunts for "DEV", reads a little-endian 16-bit address and 16-bit
// length, and forwards the payload and trailer bytes with tlast on the final
// trailer byte. Frames whose length exceeds max_payload_length (cfg port,
// reset 255) are dropped. Header bytes produce no output transaction.
// m_axis_tvalid_o rises in the cycle after an accepted body byte, through a
// single output register; s_axis_tready_o stays high whenever that register
// is empty or being drained, so bytes stream back to back at full rate.
module magic_length_frame_deframer
  import mlfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: max_payload_length
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // received bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // frame bytes out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [15:0] source_address, [31:16] payload_length,
                                        // [39:32] data_byte
  output logic        m_axis_tuser_o,   // [0] is_trailer
  output logic        m_axis_tlast_o
);

  logic    room;
  logic    byte_take;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = room;
  assign byte_take       = s_axis_tvalid_i && room;

  mlfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .byte_take_i (byte_take),
    .byte_i      (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mlfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .room_o      (room),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .res_o       (out_res)
  );

  assign m_axis_tdata_o = {out_res.data_byte, out_res.payload_length, out_res.source_address};
  assign m_axis_tuser_o = out_res.is_trailer;
  assign m_axis_tlast_o = out_res.last;

endmodule

### hw/rtl/mlfd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the deframer, bound to the top level.
// Depends on magic_length_frame_deframer_defines.svh.
`include "magic_length_frame_deframer_defines.svh"

module mlfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  logic        out_xfer;
  logic        in_frame_q;
  logic        trailer_seen_q;
  logic [31:0] hdr_q;

  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // Track the header and trailer state of the frame in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q     <= 1'b0;
      trailer_seen_q <= 1'b0;
      hdr_q          <= '0;
    end else if (out_xfer) begin
      in_frame_q     <= !m_axis_tlast_o;
      trailer_seen_q <= !m_axis_tlast_o && m_axis_tuser_o;
      hdr_q          <= m_axis_tdata_o[31:0];
    end
  end

  // A stalled transaction holds
  `MLFD_ASSERT(a_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "stalled output changed")

  // The final byte of a frame is always a trailer byte
  `MLFD_ASSERT_NEVER(a_last_trailer, m_axis_tvalid_o && m_axis_tlast_o && !m_axis_tuser_o, "tlast on a payload byte")

  // Address and length stay fixed within a frame
  `MLFD_ASSERT(a_hdr_const, out_xfer && in_frame_q |-> m_axis_tdata_o[31:0] == hdr_q, "header changed mid-frame")

  // Once the trailer starts, no payload byte follows in the same frame
  `MLFD_ASSERT(a_trailer_order, out_xfer && trailer_seen_q |-> m_axis_tuser_o, "payload byte after trailer")

endmodule

bind magic_length_frame_deframer mlfd_checker u_mlfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
